// File: hdl/circular_direction_mean_assert.svh
// Assertion macros shared by the circular direction mean RTL.
// Every assertion is clocked by clock and disabled while reset is high.
`ifndef CIRCULAR_DIRECTION_MEAN_ASSERT_SVH
`define CIRCULAR_DIRECTION_MEAN_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CDM_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define CDM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CDM_ASSERT(lbl, ante, cons, msg)
`define CDM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/cdm_pkg.sv
// Shared widths, constants and controller/datapath interface structs for the
// circular direction mean block. No dependencies.
`timescale 1ns / 1ps

package cdm_pkg;

   // Field and state widths.
   localparam int ValueWidth   = 16;
   localparam int ModuloWidth  = 16;
   localparam int PeriodWidth  = ModuloWidth + 1;
   localparam int MaxSamples   = 65536;
   localparam int CountWidth   = $clog2(MaxSamples + 1);
   localparam int SumWidth     = 64;
   localparam int PrevWidth    = 40;
   localparam int DiffWidth    = PrevWidth + 1;
   localparam int StepWidth    = PeriodWidth + 1;

   // Reset value of the modulo register.
   localparam logic [ModuloWidth-1:0] ModuloReset = ModuloWidth'(360);

   // Iterative divider: two quotient bits per cycle.
   localparam int DivisorWidth  = (CountWidth > PeriodWidth) ? CountWidth : PeriodWidth;
   localparam int DivRadixBits  = 2;
   localparam int DivShortWidth = 48;
   localparam int DivLongSteps  = SumWidth / DivRadixBits;
   localparam int DivShortSteps = DivShortWidth / DivRadixBits;
   localparam int DivCntWidth   = $clog2(DivLongSteps + 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the input transaction, clear on start_new
      logic eval;        // seed or add an in-range sample
      logic fold_start;  // start |step| mod period
      logic apply;       // add the folded sample
      logic mean_start;  // start |sum| / count
      logic mod_start;   // start quotient mod period
      logic mean_load;   // capture the reduced mean
      logic rsp_load;    // load the output register
   } cdm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_fold;
      logic count_zero;
      logic div_done;
   } cdm_status_type;

endpackage

// File: hdl/circular_direction_mean.sv
// Top level of the circular direction mean block.
// Depends on cdm_pkg, cdm_ctrl, cdm_datapath (which holds cdm_divider).
//
// Usage: each input transaction on req_ carries one direction sample with an
// accept flag and a start flag; each one returns exactly one result on rsp_
// with the running mean (Mitsuta unwrapping), a has_mean flag, the sample
// count and a saturation flag. The user must write the period on csr_ only
// while idle; the block itself does not enforce it. The work runs on the
// shared two-bit-per-cycle divider: a division and an add that fold the step
// when it lies outside half a period, then the sum over the count, then the
// reduction modulo the period; with no sample yet no division runs.
// One transaction is in work at a time; the next is taken while the previous
// result waits in the output register. A stalled receiver holds that result
// and, once the next one is ready, blocks further input. Reset clears the
// running state and the output valid, and sets the period to 360.
`timescale 1ns / 1ps

module circular_direction_mean (
   input  logic        clock,
   input  logic        reset,
   // Configuration: period of the circular quantity.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Input transactions.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_value
   input  logic [1:0]  req_tuser,   // [0] sample_accepted, [1] start_new
   // Result transactions.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] mean_direction, [32:16] sample_count
   output logic [1:0]  rsp_tuser    // [0] has_mean, [1] count_saturated
);
   import cdm_pkg::*;

   cdm_cmd_type              cmd;
   cdm_status_type           status;
   logic [ValueWidth-1:0]    mean;
   logic                     has_mean;
   logic [CountWidth-1:0]    count;
   logic                     saturated;

   cdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cdm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_sample     (req_tdata[ValueWidth-1:0]),
      .in_accepted   (req_tuser[0]),
      .in_start_new  (req_tuser[1]),
      .cmd           (cmd),
      .status        (status),
      .out_mean      (mean),
      .out_has_mean  (has_mean),
      .out_count     (count),
      .out_saturated (saturated)
   );

   // Pack the result fields, padded to whole bytes.
   assign rsp_tdata = {{(40-ValueWidth-CountWidth){1'b0}}, count, mean};
   assign rsp_tuser = {saturated, has_mean};

endmodule

// File: hdl/cdm_divider.sv
// Iterative unsigned divider, two quotient bits per cycle, for the circular
// direction mean datapath. Depends on cdm_pkg.
`timescale 1ns / 1ps
`include "circular_direction_mean_assert.svh"

module cdm_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 long_mode,
   input  logic [cdm_pkg::SumWidth-1:0]         dividend,
   input  logic [cdm_pkg::DivisorWidth-1:0]     divisor,
   output logic [cdm_pkg::SumWidth-1:0]         quotient,
   output logic [cdm_pkg::DivisorWidth-1:0]     remainder,
   output logic                                 done
);
   import cdm_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DivCntWidth-1:0]   cnt_ff, cnt_in;
   logic [SumWidth-1:0]      quo_ff, quo_in;
   logic [DivisorWidth-1:0]  rem_ff, rem_in;
   logic [DivisorWidth-1:0]  div_ff, div_in;
   logic [SumWidth-1:0]      quo_step;
   logic [DivisorWidth-1:0]  rem_step;

   // Two restoring steps per cycle on the narrow remainder.
   always_comb begin
      logic [DivisorWidth:0] trial;
      rem_step = rem_ff;
      quo_step = quo_ff;
      for (int i = 0; i < DivRadixBits; i++) begin
         trial    = {rem_step, quo_step[SumWidth-1]};
         quo_step = {quo_step[SumWidth-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial       = trial - {1'b0, div_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[DivisorWidth-1:0];
      end
   end

   // Next-state logic: a start loads the operands, then the loop runs.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         div_in  = divisor;
         rem_in  = '0;
         if (long_mode) begin
            quo_in = dividend;
            cnt_in = DivCntWidth'(DivLongSteps);
         end else begin
            quo_in = {dividend[DivShortWidth-1:0], {(SumWidth-DivShortWidth){1'b0}}};
            cnt_in = DivCntWidth'(DivShortSteps);
         end
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   // A new division is never started on top of a running one.
   `CDM_ASSERT(a_div_start_idle, start, !busy_ff, "divider started while busy")
   // The partial remainder always stays below the divisor.
   `CDM_ASSERT(a_div_rem_bound, busy_ff, rem_ff < div_ff, "remainder not below divisor")
   // The last step is followed by the done pulse.
   `CDM_ASSERT_NXT(a_div_done, busy_ff && !start && cnt_ff == DivCntWidth'(1), done_ff,
      "divider finished without done")

endmodule

// File: hdl/cdm_datapath.sv
// Datapath of the circular direction mean: modulo register, running state,
// unwrapping, shared divider and output register. Depends on cdm_pkg, cdm_divider.
`timescale 1ns / 1ps
`include "circular_direction_mean_assert.svh"

module cdm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [cdm_pkg::ModuloWidth-1:0]      csr_wr_data,
   input  logic [cdm_pkg::ValueWidth-1:0]       in_sample,
   input  logic                                 in_accepted,
   input  logic                                 in_start_new,
   input  cdm_pkg::cdm_cmd_type                 cmd,
   output cdm_pkg::cdm_status_type              status,
   output logic [cdm_pkg::ValueWidth-1:0]       out_mean,
   output logic                                 out_has_mean,
   output logic [cdm_pkg::CountWidth-1:0]       out_count,
   output logic                                 out_saturated
);
   import cdm_pkg::*;

   logic [ModuloWidth-1:0]        modulo_ff, modulo_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic [SumWidth-1:0]           sum_ff, sum_in;
   logic signed [PrevWidth-1:0]   prev_ff, prev_in;
   logic [ValueWidth-1:0]         sample_ff;
   logic                          accept_ff;
   logic [ValueWidth-1:0]         mean_ff;
   logic [ValueWidth-1:0]         rsp_mean_ff;
   logic                          rsp_has_ff;
   logic [CountWidth-1:0]         rsp_count_ff;
   logic                          rsp_sat_ff;

   logic [PeriodWidth-1:0]        period;
   logic [PeriodWidth-1:0]        half;
   logic                          take;
   logic                          seed;
   logic signed [DiffWidth-1:0]   sample_ext, prev_ext, diff, half_ext;
   logic                          above, below, in_range;
   logic [DiffWidth-1:0]          diff_mag;
   logic [PeriodWidth-1:0]        r0, limit;
   logic signed [StepWidth-1:0]   step;
   logic signed [PrevWidth-1:0]   dir_fold;
   logic [PrevWidth-1:0]          sample_wide;
   logic                          sum_neg;
   logic [SumWidth-1:0]           sum_mag;
   logic [PeriodWidth-1:0]        mean_val;

   logic                          div_start, div_long, div_done;
   logic [SumWidth-1:0]           div_dividend, div_quo;
   logic [DivisorWidth-1:0]       div_divisor, div_rem;
   logic [PeriodWidth-1:0]        rem_p;

   // A zero modulo register stands for a full 16-bit period.
   assign period = (modulo_ff == '0) ? {1'b1, {ModuloWidth{1'b0}}} : {1'b0, modulo_ff};
   assign half   = {1'b0, period[PeriodWidth-1:1]};

   assign take = accept_ff && (count_ff < CountWidth'(MaxSamples));
   assign seed = (count_ff == '0);

   // Step from the previous unwrapped direction and its range check.
   assign sample_ext = signed'({{(DiffWidth-ValueWidth){1'b0}}, sample_ff});
   assign prev_ext   = signed'({prev_ff[PrevWidth-1], prev_ff});
   assign diff       = sample_ext - prev_ext;
   assign half_ext   = signed'({{(DiffWidth-PeriodWidth){1'b0}}, half});
   assign above      = diff > half_ext;
   assign below      = diff < -half_ext;
   assign in_range   = !above && !below;
   assign diff_mag   = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
   assign sample_wide = {{(PrevWidth-ValueWidth){1'b0}}, sample_ff};

   assign rem_p = div_rem[PeriodWidth-1:0];

   // Fold the step: residue in 0..period-1, then into the half-period window.
   // A step above the window lands in (half-period, half], one below it in
   // [-half, period-half).
   always_comb begin
      if (diff[DiffWidth-1] && rem_p != '0) begin
         r0 = period - rem_p;
      end else begin
         r0 = rem_p;
      end
      limit = above ? half : (period - half - 1'b1);
      if (r0 <= limit) begin
         step = signed'({1'b0, r0});
      end else begin
         step = signed'({1'b0, r0}) - signed'({1'b0, period});
      end
      dir_fold = prev_ff + PrevWidth'(step);
   end

   // Mean: floor of sum / count, reduced into 0..period-1.
   assign sum_neg  = sum_ff[SumWidth-1];
   assign sum_mag  = sum_neg ? (~sum_ff + 1'b1) : sum_ff;
   assign mean_val = (sum_neg && rem_p != '0) ? (period - rem_p) : rem_p;

   // Divider operand selection.
   always_comb begin
      div_start    = cmd.fold_start || cmd.mean_start || cmd.mod_start;
      div_long     = cmd.mean_start;
      div_dividend = {{(SumWidth-DiffWidth){1'b0}}, diff_mag};
      div_divisor  = DivisorWidth'(period);
      if (cmd.mean_start) begin
         div_dividend = sum_mag;
         div_divisor  = DivisorWidth'(count_ff);
      end else if (cmd.mod_start) begin
         div_dividend = div_quo + SumWidth'(sum_neg && div_rem != '0);
      end
   end

   cdm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .long_mode (div_long),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Running state updates.
   always_comb begin
      modulo_in = csr_wr_en ? csr_wr_data : modulo_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      if (cmd.capture && in_start_new) begin
         count_in = '0;
         sum_in   = '0;
         prev_in  = '0;
      end
      if (cmd.eval && take && seed) begin
         count_in = CountWidth'(1);
         sum_in   = SumWidth'(sample_ff);
         prev_in  = signed'(sample_wide);
      end else if (cmd.eval && take && in_range) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SumWidth'(sample_ff);
         prev_in  = signed'(sample_wide);
      end
      if (cmd.apply) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SumWidth'(dir_fold);
         prev_in  = dir_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulo_ff <= ModuloReset;
         count_ff  <= '0;
         sum_ff    <= '0;
         prev_ff   <= '0;
      end else begin
         modulo_ff <= modulo_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         prev_ff   <= prev_in;
      end
   end

   // Captured transaction, reduced mean and output register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= in_sample;
         accept_ff <= in_accepted;
      end
      if (cmd.mean_load) begin
         mean_ff <= seed ? '0 : mean_val[ValueWidth-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_mean_ff  <= mean_ff;
         rsp_has_ff   <= !seed;
         rsp_count_ff <= count_ff;
         rsp_sat_ff   <= (count_ff >= CountWidth'(MaxSamples));
      end
   end

   assign status.need_fold  = take && !seed && !in_range;
   assign status.count_zero = seed;
   assign status.div_done   = div_done;

   assign out_mean      = rsp_mean_ff;
   assign out_has_mean  = rsp_has_ff;
   assign out_count     = rsp_count_ff;
   assign out_saturated = rsp_sat_ff;

   // The sample count never passes its limit.
   `CDM_ASSERT(a_dp_count_max, 1'b1, count_ff <= CountWidth'(MaxSamples),
      "sample count beyond limit")

endmodule

// File: hdl/cdm_ctrl.sv
// Controller state machine of the circular direction mean: sequences capture,
// unwrapping, the three divisions and the output handshake. Depends on cdm_pkg.
`timescale 1ns / 1ps
`include "circular_direction_mean_assert.svh"

module cdm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  cdm_pkg::cdm_status_type   status,
   output cdm_pkg::cdm_cmd_type      cmd
);
   import cdm_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StEval = 3'd1;
   localparam logic [2:0] StFold = 3'd2;
   localparam logic [2:0] StMean = 3'd3;
   localparam logic [2:0] StMdiv = 3'd4;
   localparam logic [2:0] StMod  = 3'd5;
   localparam logic [2:0] StOut  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = StEval;
            end
         end
         StEval: begin
            cmd.eval = 1'b1;
            if (status.need_fold) begin
               cmd.fold_start = 1'b1;
               state_in       = StFold;
            end else begin
               state_in = StMean;
            end
         end
         StFold: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               state_in  = StMean;
            end
         end
         StMean: begin
            if (status.count_zero) begin
               cmd.mean_load = 1'b1;
               state_in      = StOut;
            end else begin
               cmd.mean_start = 1'b1;
               state_in       = StMdiv;
            end
         end
         StMdiv: begin
            if (status.div_done) begin
               cmd.mod_start = 1'b1;
               state_in      = StMod;
            end
         end
         StMod: begin
            if (status.div_done) begin
               cmd.mean_load = 1'b1;
               state_in      = StOut;
            end
         end
         StOut: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Output valid: set on load, cleared once the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;

   // A result is never written over one that is still waiting.
   `CDM_ASSERT(a_ctrl_no_overwrite, cmd.rsp_load, out_free, "pending result overwritten")
   // The divider result is consumed only in the states that wait for it.
   `CDM_ASSERT(a_ctrl_apply_done, cmd.apply || cmd.mod_start, status.div_done,
      "divider result used before done")

endmodule

// File: dv/circular_mean_checker.sv
// Result checker for the circular direction mean block: tracks the period
// register, predicts every result from the accepted input transactions and compares it.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module circular_mean_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [cdm_pkg::ModuloWidth-1:0] csr_wr_data,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [15:0] sample_value
   input  logic [1:0]                      req_tuser,   // [0] sample_accepted, [1] start_new
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [39:0]                     rsp_tdata,   // [15:0] mean_direction,
                                                        // [32:16] sample_count
   input  logic [1:0]                      rsp_tuser,   // [0] has_mean, [1] count_saturated
   output int                              error_count,
   output int                              results_checked,
   output int                              expected_left
);
   import cdm_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [ValueWidth-1:0] mean_direction;
      logic                  has_mean;
      logic [CountWidth-1:0] sample_count;
      logic                  count_saturated;
   } mean_result_type;

   // Own copy of the block's register and running state.
   logic [ModuloWidth-1:0] period_setting = ModuloReset;
   logic [CountWidth-1:0]  samples_taken  = '0;
   longint                 direction_sum  = 0;
   longint                 last_direction = 0;

   mean_result_type        pending_means[$];
   mean_result_type        oldest;
   int                     errs    = 0;
   int                     checked = 0;

   // Integrates one input transaction and returns the result it must produce.
   function automatic mean_result_type predict_mean(logic [ValueWidth-1:0] sample,
                                                    logic take, logic restart);
      mean_result_type res;
      u64_type         period;
      u64_type         cnt;
      u64_type         mag;
      u64_type         quo;
      u64_type         rem;
      longint          half;
      longint          span;
      longint          sval;
      longint          step;
      longint          folds;
      period = (period_setting == '0) ? 64'd65536 : u64_type'(period_setting);
      span   = longint'(period);
      half   = longint'(period >> 1);
      sval   = sample;
      if (restart) begin
         samples_taken  = '0;
         direction_sum  = 0;
         last_direction = 0;
      end
      // A sample arriving at the full count is dropped.
      if (take && samples_taken < MaxSamples) begin
         if (samples_taken == '0) begin
            direction_sum  = sval;
            last_direction = sval;
         end else begin
            // Move the step by whole periods into -half .. half.
            step = sval - last_direction;
            if (step > half) begin
               folds = (step - half + span - 1) / span;
               step  = step - folds * span;
            end else if (step < -half) begin
               folds = (-half - step + span - 1) / span;
               step  = step + folds * span;
            end
            last_direction = last_direction + step;
            direction_sum  = direction_sum + last_direction;
         end
         samples_taken = samples_taken + 1'b1;
      end
      res                 = '0;
      res.sample_count    = samples_taken;
      res.count_saturated = (samples_taken >= MaxSamples);
      if (samples_taken != '0) begin
         // Floor of sum over count, then reduced into 0 .. period-1.
         cnt = samples_taken;
         if (direction_sum >= 0) begin
            mag = direction_sum;
            rem = (mag / cnt) % period;
         end else begin
            mag = 64'd0 - u64_type'(direction_sum);
            quo = mag / cnt + (((mag % cnt) != 64'd0) ? 64'd1 : 64'd0);
            rem = quo % period;
            if (rem != 64'd0) begin
               rem = period - rem;
            end
         end
         res.has_mean       = 1'b1;
         res.mean_direction = rem[ValueWidth-1:0];
      end
      return res;
   endfunction

   task automatic check_field(string name, u64_type want, u64_type got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         period_setting = ModuloReset;
         samples_taken  = '0;
         direction_sum  = 0;
         last_direction = 0;
         pending_means.delete();
      end else begin
         if (csr_wr_en) begin
            period_setting = csr_wr_data;
         end
         // Results first: no result can stem from a transaction accepted at this edge.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_means.size() == 0) begin
               $error("Result transaction with none outstanding: mean_direction %0d",
                      rsp_tdata[ValueWidth-1:0]);
               errs++;
            end else begin
               oldest = pending_means.pop_front();
               check_field("mean_direction", oldest.mean_direction,
                           rsp_tdata[ValueWidth-1:0]);
               check_field("sample_count", oldest.sample_count,
                           rsp_tdata[ValueWidth +: CountWidth]);
               check_field("has_mean", oldest.has_mean, rsp_tuser[0]);
               check_field("count_saturated", oldest.count_saturated, rsp_tuser[1]);
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            pending_means.push_back(predict_mean(req_tdata[ValueWidth-1:0],
                                                 req_tuser[0], req_tuser[1]));
         end
      end
      error_count     <= errs;
      results_checked <= checked;
      expected_left   <= pending_means.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the circular direction mean testbench: clock, reset, stimulus and verdict.
// Depends on cdm_pkg, circular_direction_mean and circular_mean_checker.
`timescale 1ns / 1ps

module testbench;
   import cdm_pkg::*;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [ModuloWidth-1:0] csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata   = '0;   // [15:0] sample_value
   logic [1:0]             req_tuser   = '0;   // [0] sample_accepted, [1] start_new
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [39:0]            rsp_tdata;          // [15:0] mean_direction, [32:16] sample_count
   logic [1:0]             rsp_tuser;          // [0] has_mean, [1] count_saturated

   int                     error_count;
   int                     results_checked;
   int                     expected_left;
   int                     items_sent    = 0;
   int                     settings_used = 1;
   int                     stall_left    = 0;
   logic                   idle_on       = 1'b1;
   logic                   stall_on      = 1'b1;
   logic [ModuloWidth-1:0] modulo_now    = ModuloReset;

   circular_direction_mean dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   circular_mean_checker mean_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .error_count     (error_count),
      .results_checked (results_checked),
      .expected_left   (expected_left)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // Receiver stalls at random while stalling is enabled.
   always @(posedge clock) begin
      if (!stall_on || stall_left == 0) begin
         rsp_tready <= 1'b1;
         if (stall_on && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
         end
      end else begin
         rsp_tready <= 1'b0;
         stall_left--;
      end
   end

   // Offers one input transaction and waits until it is taken. Valid stays
   // high afterwards so that back-to-back transactions need no extra edge.
   task automatic send_sample(logic [15:0] value, logic take, logic restart);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {restart, take};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Holds the input until every predicted result has been returned.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_checked != items_sent) @(posedge clock);
   endtask

   // The period is changed only while the block is idle.
   task automatic write_modulo(logic [ModuloWidth-1:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      modulo_now = value;
      settings_used++;
   endtask

   initial begin
      int          period;
      int          step;
      int          phase;
      int          len;
      int          drift;
      int          walk;
      logic [15:0] value;
      logic        take;
      logic        restart;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset period of 360.
      send_sample(16'd0, 1'b0, 1'b0);       // nothing accepted yet: no mean
      send_sample(16'd0, 1'b1, 1'b1);       // seed
      send_sample(16'd359, 1'b1, 1'b0);     // wraps backwards across zero
      send_sample(16'd179, 1'b1, 1'b0);     // step of exactly half a period
      send_sample(16'd178, 1'b1, 1'b0);     // small step of minus one
      send_sample(16'd358, 1'b1, 1'b0);     // step of exactly half a period again
      send_sample(16'hFFFF, 1'b0, 1'b0);    // ignored sample
      send_sample(16'hFFFF, 1'b1, 1'b0);    // far above the period: many folds
      send_sample(16'd0, 1'b0, 1'b1);       // clear only
      send_sample(16'hFFFF, 1'b1, 1'b1);    // seed above the period
      send_sample(16'd10, 1'b1, 1'b1);      // negative sum with a remainder
      send_sample(16'd350, 1'b1, 1'b0);
      send_sample(16'd340, 1'b1, 1'b0);
      // Smallest period.
      write_modulo(16'd1);
      send_sample(16'd0, 1'b1, 1'b1);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd1, 1'b1, 1'b0);
      // A zero register stands for a period of 65536.
      write_modulo(16'd0);
      send_sample(16'hFFFF, 1'b1, 1'b1);
      send_sample(16'd0, 1'b1, 1'b0);
      send_sample(16'd32768, 1'b1, 1'b0);
      send_sample(16'd32767, 1'b1, 1'b0);
      // Period change in the middle of a running mean.
      write_modulo(16'hFFFF);
      send_sample(16'hFFFE, 1'b1, 1'b0);
      send_sample(16'd0, 1'b1, 1'b0);
      write_modulo(16'd2);
      send_sample(16'd1, 1'b1, 1'b1);
      send_sample(16'd0, 1'b1, 1'b0);
      write_modulo(16'd3);
      send_sample(16'd2, 1'b1, 1'b0);
      send_sample(16'd0, 1'b0, 1'b0);

      // Random phases, each under one period setting. Most transactions form
      // runs that wander, drift up or drift down; a few are noise.
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       write_modulo(16'd360);
            1:       write_modulo(16'd1);
            2:       write_modulo(16'hFFFF);
            3:       write_modulo(16'd0);
            4:       write_modulo(16'd2);
            5:       write_modulo(16'd3);
            default: begin
               if (phase % 2 == 0) begin
                  write_modulo(16'($urandom_range(4, 64)));
               end else begin
                  write_modulo(16'($urandom_range(1, 65535)));
               end
            end
         endcase
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         drift    = $urandom_range(0, 2);
         period   = (modulo_now == '0) ? 65536 : int'(modulo_now);
         walk     = $urandom_range(0, period - 1);
         for (len = 0; len < 160; len++) begin
            step = $urandom_range(period / 4, period / 2);
            case (drift)
               0:       value = 16'($urandom_range(0, period - 1));
               1:       value = 16'((walk + step) % period);
               default: value = 16'((walk + period - step) % period);
            endcase
            if ($urandom_range(0, 19) == 0) begin
               value = 16'($urandom);
            end
            walk = value;
            if (len == 0) begin
               // Half the phases carry the running mean across the period change.
               take    = 1'b1;
               restart = 1'($urandom_range(0, 1));
            end else begin
               take    = ($urandom_range(0, 99) < 88);
               restart = ($urandom_range(0, 99) < 3);
            end
            if ($urandom_range(0, 149) == 0) begin
               drain_results();
            end
            send_sample(value, take, restart);
         end
      end

      drain_results();
      repeat (120) @(posedge clock);
      $display("Summary: %0d input transactions under %0d period settings,", items_sent,
               settings_used);
      $display("including the extreme periods, samples above the period and period changes.");
      if (error_count + expected_left == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Overall limit, several times the slowest correct run.
   initial begin
      #40_000_000;
      $display("Timeout: results stopped arriving or the run overran its limit.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
